// ===== design/twcs_pkg.sv =====
`timescale 1ns / 1ps
package twcs_pkg;

  localparam int TEX_W_DEF    = 64;
  localparam int TEX_H_DEF    = 64;
  localparam int SCREEN_H_DEF = 1000;
  localparam int SCREEN_W_DEF = 1920;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam logic [1:0] REG_CEIL  = 2'd0;
  localparam logic [1:0] REG_WALL  = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;

  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_EAST  = 2'd2;
  localparam logic [1:0] TEX_WEST  = 2'd3;

  localparam logic CFG_CEILING = 1'b0;
  localparam logic CFG_FLOOR   = 1'b1;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ===== design/textured_wall_column_shader.sv =====
`timescale 1ns / 1ps
// Textured wall column shader.
// Input channel (in_*): one word per cycle, valid/stall. func 0 writes a texel
// into the texture memory, func 1 shades one pixel. Off-screen pixels and
// texel writes give no output word.
// Output channel (out_*): one word per shaded pixel, in input order.
// Config channel (cfg_*): index 0 ceiling color, 1 floor color; always ready.
// Throughput: one word per cycle while out_stall does not hold the pipeline.
// FW = $clog2(TEX_H+1) + 24 is the quotient width of the restoring divider
// that forms the texture step, one quotient bit a stage.
// The whole pipeline advances together; when the output word is held by
// out_stall, every stage holds and in_stall is raised, nothing is lost.
// Reset clears the valid bits and both colors; texture memory contents are
// undefined until written.
module textured_wall_column_shader
  import twcs_pkg::*;
#(
  parameter int TEX_W    = TEX_W_DEF,
  parameter int TEX_H    = TEX_H_DEF,
  parameter int SCREEN_H = SCREEN_H_DEF,
  parameter int SCREEN_W = SCREEN_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [1:0]         in_texture_id,
  input  logic [11:0]        in_texel_address,
  input  logic [31:0]        in_texel_value,
  input  logic [10:0]        in_column,
  input  logic [9:0]         in_row,
  input  logic [9:0]         in_top_row,
  input  logic [9:0]         in_bottom_row,
  input  logic [19:0]        in_wall_height,
  input  logic [23:0]        in_hit_coord,
  input  logic signed [17:0] in_ray_angle,
  input  logic               in_hit_side,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        out_column,
  output logic [9:0]         out_row,
  output logic [31:0]        out_color,
  output logic [1:0]         out_region,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int FW  = $clog2(TEX_H + 1) + 24;
  localparam int YW  = FW + 22;
  localparam int TRW = $clog2(TEX_H + 1);
  localparam int CW  = $clog2(TEX_W);
  localparam int K   = TEX_W / 32;
  localparam int M   = (1 << 20) / TEX_W;
  localparam int NS  = FW + 4;
  localparam logic [FW-1:0] NUM = FW'(TEX_H) << 24;

  typedef struct packed {
    logic             load;
    logic [1:0]       region;
    logic [10:0]      col;
    logic [9:0]       row;
    logic [1:0]       tex;
    logic [13:0]      addr;
    logic [31:0]      wdata;
    logic [19:0]      h;
    logic [20:0]      s;
    logic [9:0]       diff;
    logic [18:0]      v;
    logic [18:0]      qe;
    logic [9:0]       r;
    logic [CW-1:0]    tcol;
    logic [19:0]      rem;
    logic [FW-1:0]    q;
    logic [37:0]      p_lo;
    logic [FW+3:0]    p_hi;
    logic [FW+9:0]    d;
    logic [FW+20:0]   start;
    logic [TRW-1:0]   trow;
  } stage_t;

  stage_t     st_r [0:NS];
  logic       stv_r [0:NS];
  stage_t     st_nxt [0:NS-1];
  stage_t     prep;
  logic       en;
  logic       draw_ok;
  logic [31:0] ceil_r, floor_r;
  logic [31:0] mem [0:16383];
  logic [31:0] rd_r;
  stage_t      mst_r;
  logic        mv_r;
  logic        out_valid_r;
  logic [10:0] out_column_r;
  logic [9:0]  out_row_r;
  logic [31:0] out_color_r;
  logic [1:0]  out_region_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r  <= '0;
      floor_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_CEILING) ceil_r <= cfg_data;
      else floor_r <= cfg_data;
    end
  end

  // input preparation
  always_comb begin
    logic signed [18:0] a;
    logic signed [23:0] sv;
    logic [26:0]        hk;
    prep        = '0;
    prep.load   = (in_func == FUNC_LOAD);
    prep.col    = in_column;
    prep.row    = in_row;
    prep.wdata  = in_texel_value;
    prep.addr   = {in_texture_id, in_texel_address};
    prep.h      = (in_wall_height == 20'd0) ? 20'd1 : in_wall_height;
    if (in_row < in_top_row) prep.region = REG_CEIL;
    else if (in_row >= in_bottom_row) prep.region = REG_FLOOR;
    else prep.region = REG_WALL;
    a = 19'(in_ray_angle);
    if (a < 0) a = a + 19'sd65536;
    if (a > 19'sd65536) a = a - 19'sd65536;
    if (!in_hit_side) prep.tex = (a > 19'sd16384 && a < 19'sd49152) ? TEX_EAST : TEX_WEST;
    else prep.tex = (a > 19'sd0 && a < 19'sd32768) ? TEX_SOUTH : TEX_NORTH;
    sv = ((24'(in_top_row) - 24'(SCREEN_H / 2)) <<< 9) + 24'(prep.h);
    prep.s    = sv[23] ? 21'd0 : sv[20:0];
    prep.diff = in_row - in_top_row;
    hk        = 27'(in_hit_coord) * 27'(K);
    prep.v    = hk[26:8];
  end

  assign draw_ok = (in_func == FUNC_LOAD) ||
                   ((32'(in_column) < 32'(SCREEN_W)) && (32'(in_row) < 32'(SCREEN_H)));

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      always_comb begin
        logic [20:0] t;
        logic [34:0] pm;
        logic [27:0] rw;
        logic [YW-1:0] y;
        logic [19:0] idx;
        st_nxt[k] = st_r[k];
        if (k < FW) begin
          t = {st_r[k].rem, NUM[FW-1-k]};
          if (t >= {1'b0, st_r[k].h}) begin
            st_nxt[k].rem = 20'(t - {1'b0, st_r[k].h});
            st_nxt[k].q   = {st_r[k].q[FW-2:0], 1'b1};
          end else begin
            st_nxt[k].rem = t[19:0];
            st_nxt[k].q   = {st_r[k].q[FW-2:0], 1'b0};
          end
        end
        if (k == 0) begin
          pm = 35'(st_r[k].v) * 35'(M);
          st_nxt[k].qe = 19'(pm[34:20]);
        end
        if (k == 1) begin
          rw = 28'(st_r[k].v) - 28'(st_r[k].qe) * 28'(TEX_W);
          st_nxt[k].r = rw[9:0];
        end
        if (k == 2) begin
          st_nxt[k].tcol = (32'(st_r[k].r) >= 32'(TEX_W)) ?
                           CW'(32'(st_r[k].r) - 32'(TEX_W)) : CW'(st_r[k].r);
        end
        if (k == FW) begin
          st_nxt[k].p_lo = 38'(st_r[k].s) * 38'(st_r[k].q[16:0]);
          st_nxt[k].p_hi = (FW+4)'(st_r[k].s) * (FW+4)'(st_r[k].q[FW-1:17]);
          st_nxt[k].d    = (FW+10)'(st_r[k].diff) * (FW+10)'(st_r[k].q);
        end
        if (k == FW + 1) begin
          st_nxt[k].start = ((FW+21)'(st_r[k].p_hi) << 17) + (FW+21)'(st_r[k].p_lo);
        end
        if (k == FW + 2) begin
          y = YW'(st_r[k].start) + (YW'(st_r[k].d) << 9);
          if (y[YW-1:25] > (YW-25)'(TEX_H - 1)) st_nxt[k].trow = TRW'(TEX_H - 1);
          else st_nxt[k].trow = y[25 +: TRW];
        end
        if (k == FW + 3) begin
          idx = 20'(st_r[k].trow) * 20'(TEX_W) + 20'(st_r[k].tcol);
          if (!st_r[k].load) st_nxt[k].addr = {st_r[k].tex, idx[11:0]};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stv_r[k+1] <= 1'b0;
        end else if (en) begin
          stv_r[k+1] <= stv_r[k];
        end
        if (en) st_r[k+1] <= st_nxt[k];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stv_r[0] <= 1'b0;
    end else if (en) begin
      stv_r[0] <= in_valid && draw_ok;
    end
    if (en) st_r[0] <= prep;
  end

  always_ff @(posedge clk) begin
    if (en && stv_r[NS] && st_r[NS].load) mem[st_r[NS].addr] <= st_r[NS].wdata;
    if (en) rd_r <= mem[st_r[NS].addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= stv_r[NS] && !st_r[NS].load;
    end
    if (en) mst_r <= st_r[NS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mv_r;
    end
    if (en) begin
      out_column_r <= mst_r.col;
      out_row_r    <= mst_r.row;
      out_region_r <= mst_r.region;
      case (mst_r.region)
        REG_CEIL:  out_color_r <= ceil_r;
        REG_FLOOR: out_color_r <= floor_r;
        default:   out_color_r <= swap_bytes(rd_r);
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_column = out_column_r;
  assign out_row    = out_row_r;
  assign out_color  = out_color_r;
  assign out_region = out_region_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb
  import twcs_pkg::*;
();

  typedef struct {
    logic               func;
    logic [1:0]         tid;
    logic [11:0]        taddr;
    logic [31:0]        tval;
    logic [10:0]        col;
    logic [9:0]         row;
    logic [9:0]         top;
    logic [9:0]         bot;
    logic [19:0]        wh;
    logic [23:0]        hit;
    logic signed [17:0] ang;
    logic               side;
  } px_word_t;

  typedef struct {
    logic [10:0] col;
    logic [9:0]  row;
    logic [31:0] color;
    logic [1:0]  region;
  } pixel_t;

  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = FUNC_LOAD;
  logic [1:0] in_texture_id = '0;
  logic [11:0] in_texel_address = '0;
  logic [31:0] in_texel_value = '0;
  logic [10:0] in_column = '0;
  logic [9:0] in_row = '0;
  logic [9:0] in_top_row = '0;
  logic [9:0] in_bottom_row = '0;
  logic [19:0] in_wall_height = '0;
  logic [23:0] in_hit_coord = '0;
  logic signed [17:0] in_ray_angle = '0;
  logic in_hit_side = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [10:0] out_column;
  logic [9:0] out_row;
  logic [31:0] out_color;
  logic [1:0] out_region;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_CEILING;
  logic [31:0] cfg_data = '0;

  textured_wall_column_shader dut (.*);

  always #5 clk = ~clk;

  logic [31:0] texels [16384];
  bit written [16384];
  logic [31:0] ceil_rgba = '0;
  logic [31:0] floor_rgba = '0;
  pixel_t pending_pixels [$];
  bit idle_en = 1'b1;
  int hold_req = 0;
  int errors = 0;
  int n_words = 0, n_ceil = 0, n_wall = 0, n_floor = 0, n_off = 0;

  function automatic bit on_screen(px_word_t w);
    return w.col < SCREEN_W_DEF && w.row < SCREEN_H_DEF;
  endfunction

  function automatic bit in_wall(px_word_t w);
    return w.row >= w.top && w.row < w.bot;
  endfunction

  function automatic logic [13:0] texel_slot(px_word_t w);
    longint unsigned h, factor, tcol, y, trow;
    longint start, a;
    logic [1:0] tid;
    h = (w.wh == 0) ? 1 : w.wh;
    factor = (longint'(TEX_H_DEF) << 24) / h;
    tcol = ((longint'(w.hit) * (TEX_W_DEF / 32)) >> 8) % TEX_W_DEF;
    start = (longint'(w.top) - SCREEN_H_DEF / 2) * 512 + longint'(h);
    start = start * longint'(factor);
    if (start < 0) start = 0;
    y = longint'(start) + (((longint'(w.row) - longint'(w.top)) * factor) << 9);
    trow = y >> 25;
    if (trow > TEX_H_DEF - 1) trow = TEX_H_DEF - 1;
    a = longint'(w.ang);
    if (a < 0) a += 65536;
    if (a > 65536) a -= 65536;
    if (w.side == 1'b0) tid = (a > 16384 && a < 49152) ? TEX_EAST : TEX_WEST;
    else tid = (a > 0 && a < 32768) ? TEX_SOUTH : TEX_NORTH;
    return {tid, 12'(trow * TEX_W_DEF + tcol)};
  endfunction

  function automatic void shade_pixel(px_word_t w);
    pixel_t p;
    logic [31:0] t;
    if (w.func == FUNC_LOAD) begin
      texels[{w.tid, w.taddr}] = w.tval;
      written[{w.tid, w.taddr}] = 1'b1;
      return;
    end
    if (!on_screen(w)) begin
      n_off++;
      return;
    end
    p.col = w.col;
    p.row = w.row;
    if (w.row < w.top) begin
      p.color = ceil_rgba;
      p.region = REG_CEIL;
      n_ceil++;
    end else if (w.row >= w.bot) begin
      p.color = floor_rgba;
      p.region = REG_FLOOR;
      n_floor++;
    end else begin
      t = texels[texel_slot(w)];
      p.color = {t[7:0], t[15:8], t[23:16], t[31:24]};
      p.region = REG_WALL;
      n_wall++;
    end
    pending_pixels.push_back(p);
  endfunction

  task automatic send_word(px_word_t w);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(3) == 0) begin
      gap = $urandom_range(18, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = w.func;
    in_texture_id = w.tid;
    in_texel_address = w.taddr;
    in_texel_value = w.tval;
    in_column = w.col;
    in_row = w.row;
    in_top_row = w.top;
    in_bottom_row = w.bot;
    in_wall_height = w.wh;
    in_hit_coord = w.hit;
    in_ray_angle = w.ang;
    in_hit_side = w.side;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    n_words++;
    shade_pixel(w);
  endtask

  function automatic px_word_t rand_word();
    px_word_t w;
    w.func = 1'($urandom);
    w.tid = 2'($urandom);
    w.taddr = 12'($urandom);
    w.tval = $urandom;
    w.col = 11'($urandom);
    w.row = 10'($urandom);
    w.top = 10'($urandom);
    w.bot = 10'($urandom);
    w.wh = 20'($urandom);
    w.hit = 24'($urandom);
    w.ang = 18'($urandom);
    w.side = 1'($urandom);
    return w;
  endfunction

  // make sure the wall texel a draw will fetch has been loaded first
  task automatic send_draw(px_word_t w);
    px_word_t ld;
    logic [13:0] slot;
    w.func = FUNC_DRAW;
    if (on_screen(w) && in_wall(w)) begin
      slot = texel_slot(w);
      if (!written[slot]) begin
        ld = rand_word();
        ld.func = FUNC_LOAD;
        ld.tid = slot[13:12];
        ld.taddr = slot[11:0];
        send_word(ld);
      end
    end
    send_word(w);
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    end_stream();
    wait (pending_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CEILING) ceil_rgba = value;
    else floor_rgba = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic px_word_t wall_draw();
    px_word_t w;
    w = rand_word();
    w.col = 11'($urandom_range(SCREEN_W_DEF - 1));
    w.top = 10'($urandom_range(SCREEN_H_DEF));
    w.bot = 10'($urandom_range(SCREEN_H_DEF, w.top));
    w.row = 10'($urandom_range(SCREEN_H_DEF - 1));
    case ($urandom_range(3))
      0: w.wh = 20'($urandom_range(4096));
      1: w.wh = 20'((w.bot - w.top) << 8);
      default: w.wh = 20'($urandom);
    endcase
    return w;
  endfunction

  task automatic test_directed();
    px_word_t w;
    int angs [7] = '{-65536, 0, 16384, 32768, 49152, 65536, 131071};
    w = rand_word();
    w.func = FUNC_LOAD;
    w.tid = TEX_WEST;
    w.taddr = 12'hFFF;
    w.tval = 32'h1234_5678;
    send_word(w);
    w.tval = 32'hFFFF_FFFF;
    w.taddr = 12'h000;
    send_word(w);
    w = wall_draw();
    w.col = 11'd0; w.row = 10'd0; w.top = 10'd10; w.bot = 10'd20;
    send_draw(w);
    w.row = 10'(SCREEN_H_DEF - 1); w.col = 11'(SCREEN_W_DEF - 1);
    send_draw(w);
    w.row = 10'd15; w.top = 10'd20; w.bot = 10'd5;
    send_draw(w);
    w.row = 10'd10;
    send_draw(w);
    w.col = 11'(SCREEN_W_DEF);
    send_draw(w);
    w.col = 11'h7FF; w.row = 10'd0;
    send_draw(w);
    w.col = 11'd3; w.row = 10'(SCREEN_H_DEF);
    send_draw(w);
    w.row = 10'h3FF;
    send_draw(w);
    for (int i = 0; i < 7; i++) begin
      w = wall_draw();
      w.ang = 18'(angs[i]);
      w.side = 1'(i);
      w.top = 10'd0; w.bot = 10'(SCREEN_H_DEF); w.row = 10'(i * 140);
      w.wh = (i == 0) ? 20'd0 : (i == 1) ? 20'hFFFFF : 20'(i * 300);
      w.hit = (i == 2) ? 24'hFFFFFF : 24'(i * 9000);
      send_draw(w);
      w.side = ~w.side;
      w.top = 10'(SCREEN_H_DEF - 1);
      w.row = 10'(SCREEN_H_DEF - 1);
      send_draw(w);
    end
  endtask

  task automatic test_random(int count);
    px_word_t w;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          w = rand_word();
          w.func = FUNC_LOAD;
          send_word(w);
        end
        2: send_draw(rand_word());
        default: send_draw(wall_draw());
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    idle_en = 1'b0;
    for (int i = 0; i < 80; i++) send_draw(wall_draw());
    idle_en = 1'b1;
  endtask

  task automatic test_colors();
    write_reg(CFG_CEILING, 32'hFFFF_FFFF);
    write_reg(CFG_FLOOR, 32'h0000_0000);
    test_random(60);
    write_reg(CFG_CEILING, 32'h0000_0000);
    write_reg(CFG_FLOOR, 32'hFFFF_FFFF);
    test_random(60);
    write_reg(CFG_CEILING, $urandom);
    write_reg(CFG_FLOOR, $urandom);
  endtask

  int hold_cnt = 0;
  int long_cnt = 0;
  always @(negedge clk) begin
    if (hold_req > 0) begin
      long_cnt = hold_req;
      hold_req = 0;
    end
    if (long_cnt > 0) long_cnt--;
    if (hold_cnt > 0) hold_cnt--;
    else if (idle_en && $urandom_range(5) == 0) hold_cnt = $urandom_range(18, 1);
    out_stall = (long_cnt > 0) || (hold_cnt > 0);
  end

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel col=%0d row=%0d", out_column, out_row);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_column !== e.col) begin
          $error("out_column exp %0d got %0d", e.col, out_column); errors++;
        end
        if (out_row !== e.row) begin
          $error("out_row exp %0d got %0d", e.row, out_row); errors++;
        end
        if (out_color !== e.color) begin
          $error("color exp %h got %h", e.color, out_color); errors++;
        end
        if (out_region !== e.region) begin
          $error("region exp %0d got %0d", e.region, out_region); errors++;
        end
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout with %0d pixels pending", pending_pixels.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    write_reg(CFG_CEILING, 32'hA1B2_C3D4);
    write_reg(CFG_FLOOR, 32'h5566_7788);
    test_directed();
    test_random(150);
    test_backpressure();
    test_colors();
    test_random(70);
    idle_en = 1'b0;
    test_random(70);
    end_stream();
    wait (pending_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words: %0d ceiling, %0d wall, %0d floor, %0d off screen",
             n_words, n_ceil, n_wall, n_floor, n_off);
    $display("color registers swept through all-ones and zero, long output hold done");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/twcs_pkg.sv
design/textured_wall_column_shader.sv
tb/sv/tb.sv
